// ===== design/wksq_pkg.sv =====
`timescale 1ns / 1ps

package wksq_pkg;

  localparam int DEF_CAPACITY    = 16;
  localparam int DEF_VALUE_WIDTH = 16;

  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int GRADE_W   = 14;
  localparam int COURSES_W = 8;
  localparam int KEY_W     = 23;
  localparam int PROD_W    = GRADE_W + COURSES_W;
  localparam int COUNT_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = GRADE_W;

  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRADE_CEILING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COURSE_TOTAL  = 1'd1;

  localparam logic [GRADE_W-1:0]   GRADE_CEILING_RST = 14'd1000;
  localparam logic [COURSES_W-1:0] COURSE_TOTAL_RST  = 8'd40;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    logic [GRADE_W-1:0]   grade;
    logic [COURSES_W-1:0] courses;
    logic [KEY_W-1:0]     key;
  } slot_meta_t;

  typedef struct packed {
    cell_op_t   op;
    slot_meta_t meta;
  } cell_ctrl_t;

endpackage

// ===== design/wksq_if.sv =====
`timescale 1ns / 1ps

interface wksq_req_if #(
  parameter int VALUE_WIDTH = wksq_pkg::DEF_VALUE_WIDTH
);
  logic                               valid;
  logic                               ready;
  logic [wksq_pkg::CMD_W-1:0]         cmd;
  logic [VALUE_WIDTH-1:0]             item_value;
  logic [wksq_pkg::GRADE_W-1:0]       grade;
  logic [wksq_pkg::COURSES_W-1:0]     courses;

  modport source (output valid, cmd, item_value, grade, courses, input ready);
  modport sink   (input valid, cmd, item_value, grade, courses, output ready);
endinterface

interface wksq_rsp_if #(
  parameter int VALUE_WIDTH = wksq_pkg::DEF_VALUE_WIDTH
);
  logic                               valid;
  logic                               ready;
  logic [wksq_pkg::STATUS_W-1:0]      status;
  logic [VALUE_WIDTH-1:0]             front_value;
  logic [wksq_pkg::GRADE_W-1:0]       front_grade;
  logic [wksq_pkg::COURSES_W-1:0]     front_courses;
  logic [wksq_pkg::KEY_W-1:0]         front_key;
  logic [wksq_pkg::COUNT_W-1:0]       entry_count;
  logic                               is_empty;

  modport source (output valid, status, front_value, front_grade, front_courses,
                  front_key, entry_count, is_empty, input ready);
  modport sink   (input valid, status, front_value, front_grade, front_courses,
                  front_key, entry_count, is_empty, output ready);
endinterface

// ===== design/wksq_cell.sv =====
`timescale 1ns / 1ps

module wksq_cell #(
  parameter int CELL_IDX    = 0,
  parameter int COUNT_BITS  = 5,
  parameter int VALUE_WIDTH = wksq_pkg::DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  wksq_pkg::cell_ctrl_t   ctrl,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  logic [COUNT_BITS-1:0]  count,
  input  logic                   left_ge,
  input  wksq_pkg::slot_meta_t   left_meta,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  wksq_pkg::slot_meta_t   right_meta,
  input  logic [VALUE_WIDTH-1:0] right_value,
  output logic                   ge,
  output wksq_pkg::slot_meta_t   meta,
  output logic [VALUE_WIDTH-1:0] value
);

  logic occupied;

  // Empty cells count as "new key wins" so the first free slot takes an append.
  assign occupied = count > COUNT_BITS'(CELL_IDX);
  assign ge       = !occupied || (ctrl.meta.key >= meta.key);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      wksq_pkg::CELL_INSERT: begin
        if (left_ge) begin
          meta  <= left_meta;
          value <= left_value;
        end else if (ge) begin
          meta  <= ctrl.meta;
          value <= new_value;
        end
      end
      wksq_pkg::CELL_REMOVE: begin
        meta  <= right_meta;
        value <= right_value;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/weighted_key_sorted_priority_queue.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Payload                                               Transfer
// req      in   cmd, item_value, grade, courses                       valid & ready
// rsp      out  status, front_value/grade/courses/key, entry_count,   valid & ready
//               is_empty
// cfg      in   cfg_index, cfg_data                                   cfg_write
//
// A transfer on req is registered with its key in the key stage; all cells then compare
// the key in parallel and shift at the edge that loads the output register, and the
// result shows on rsp from that register and the cells. One item per cycle is sustained
// while rsp is taken; rsp waits hold the item at the key stage.
// rst is synchronous: count, config and handshake state clear; cell contents do not.
module weighted_key_sorted_priority_queue #(
  parameter int CAPACITY    = wksq_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = wksq_pkg::DEF_VALUE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  wksq_req_if.sink                        req,
  wksq_rsp_if.source                      rsp,
  input  logic                            cfg_write,
  input  logic [wksq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wksq_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [wksq_pkg::GRADE_W-1:0]   grade_ceiling;
  logic [wksq_pkg::COURSES_W-1:0] course_total;

  logic                          s1_valid;
  logic [wksq_pkg::CMD_W-1:0]    s1_cmd;
  logic [VALUE_WIDTH-1:0]        s1_value;
  wksq_pkg::slot_meta_t          s1_meta;
  logic                          s1_go;

  logic [wksq_pkg::PROD_W-1:0]   prod_grade;
  logic [wksq_pkg::PROD_W-1:0]   prod_courses;
  logic [wksq_pkg::KEY_W-1:0]    key_in;

  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_next;
  logic                          is_full;
  logic                          is_zero;

  logic                          out_valid;
  logic [wksq_pkg::STATUS_W-1:0] out_status;
  logic [wksq_pkg::STATUS_W-1:0] status_next;

  wksq_pkg::cell_ctrl_t          ctrl;
  logic                          ge     [CAPACITY];
  wksq_pkg::slot_meta_t          meta   [CAPACITY];
  logic [VALUE_WIDTH-1:0]        value  [CAPACITY];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      grade_ceiling <= wksq_pkg::GRADE_CEILING_RST;
      course_total  <= wksq_pkg::COURSE_TOTAL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        wksq_pkg::REG_GRADE_CEILING: grade_ceiling <= cfg_data;
        wksq_pkg::REG_COURSE_TOTAL:  course_total  <= cfg_data[wksq_pkg::COURSES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // key = grade*course_total + courses*grade_ceiling
  assign prod_grade   = req.grade * course_total;
  assign prod_courses = req.courses * grade_ceiling;
  assign key_in       = {1'b0, prod_grade} + {1'b0, prod_courses};

  assign is_full = count == CNT_W'(CAPACITY);
  assign is_zero = count == '0;
  assign s1_go   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !rst && (!s1_valid || s1_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_cmd          <= req.cmd;
      s1_value        <= req.item_value;
      s1_meta.grade   <= req.grade;
      s1_meta.courses <= req.courses;
      s1_meta.key     <= key_in;
    end
  end

  always_comb begin
    ctrl.meta   = s1_meta;
    ctrl.op     = wksq_pkg::CELL_HOLD;
    count_next  = count;
    status_next = wksq_pkg::STATUS_DONE;
    case (s1_cmd)
      wksq_pkg::CMD_ENQUEUE: begin
        if (is_full) begin
          status_next = wksq_pkg::STATUS_FULL;
        end else begin
          ctrl.op    = s1_go ? wksq_pkg::CELL_INSERT : wksq_pkg::CELL_HOLD;
          count_next = count + 1'b1;
        end
      end
      wksq_pkg::CMD_DEQUEUE: begin
        if (is_zero) begin
          status_next = wksq_pkg::STATUS_EMPTY;
        end else begin
          ctrl.op    = s1_go ? wksq_pkg::CELL_REMOVE : wksq_pkg::CELL_HOLD;
          count_next = count - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s1_go) begin
        count      <= count_next;
        out_status <= status_next;
        out_valid  <= 1'b1;
      end else if (rsp.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // cell row: each cell sees its left neighbor's compare and both neighbors' data
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   l_ge;
    wksq_pkg::slot_meta_t   l_meta;
    logic [VALUE_WIDTH-1:0] l_value;
    wksq_pkg::slot_meta_t   r_meta;
    logic [VALUE_WIDTH-1:0] r_value;

    if (i == 0) begin : g_head
      assign l_ge    = 1'b0;
      assign l_meta  = s1_meta;
      assign l_value = s1_value;
    end else begin : g_body
      assign l_ge    = ge[i-1];
      assign l_meta  = meta[i-1];
      assign l_value = value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_meta  = meta[i];
      assign r_value = value[i];
    end else begin : g_mid
      assign r_meta  = meta[i+1];
      assign r_value = value[i+1];
    end

    wksq_cell #(
      .CELL_IDX    (i),
      .COUNT_BITS  (CNT_W),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_value   (s1_value),
      .count       (count),
      .left_ge     (l_ge),
      .left_meta   (l_meta),
      .left_value  (l_value),
      .right_meta  (r_meta),
      .right_value (r_value),
      .ge          (ge[i]),
      .meta        (meta[i]),
      .value       (value[i])
    );
  end

  // cells only move when the output register loads, so the front stays put while stalled
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.front_value   = is_zero ? '0 : value[0];
  assign rsp.front_grade   = is_zero ? '0 : meta[0].grade;
  assign rsp.front_courses = is_zero ? '0 : meta[0].courses;
  assign rsp.front_key     = is_zero ? '0 : meta[0].key;
  assign rsp.entry_count   = wksq_pkg::COUNT_W'(count);
  assign rsp.is_empty      = is_zero;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_cmd == wksq_pkg::CMD_ENQUEUE && is_full)
      |=> (out_status == wksq_pkg::STATUS_FULL && is_full))
    else $error("enqueue on full queue not refused");

  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_cmd == wksq_pkg::CMD_DEQUEUE && !is_zero)
      |=> (count == $past(count) - 1'b1))
    else $error("dequeue did not drop the count");

  a_front_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (meta[0].key >= meta[1].key))
    else $error("front pair out of key order");

  a_stall_holds_cells: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> (ctrl.op == wksq_pkg::CELL_HOLD || !out_valid
      || $stable(count)))
    else $error("cells moved while result stalled");
`endif

endmodule

// ===== dv/weighted_key_sorted_priority_queue_test.sv =====
`timescale 1ns / 1ps

module weighted_key_sorted_priority_queue_test;

  localparam int CAPACITY    = wksq_pkg::DEF_CAPACITY;
  localparam int VALUE_WIDTH = wksq_pkg::DEF_VALUE_WIDTH;
  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_HOLD    = 60;
  localparam int DRAIN_CYCLES = 4;

  // cmd encoding 3 is unused; the block treats it as a report
  localparam logic [wksq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [wksq_pkg::CMD_W-1:0]     cmd;
    logic [VALUE_WIDTH-1:0]         value;
    logic [wksq_pkg::GRADE_W-1:0]   grade;
    logic [wksq_pkg::COURSES_W-1:0] courses;
  } queue_cmd_t;

  typedef struct packed {
    logic [wksq_pkg::STATUS_W-1:0]  status;
    logic [VALUE_WIDTH-1:0]         front_value;
    logic [wksq_pkg::GRADE_W-1:0]   front_grade;
    logic [wksq_pkg::COURSES_W-1:0] front_courses;
    logic [wksq_pkg::KEY_W-1:0]     front_key;
    logic [wksq_pkg::COUNT_W-1:0]   entry_count;
    logic                           is_empty;
  } front_report_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0]         value;
    logic [wksq_pkg::GRADE_W-1:0]   grade;
    logic [wksq_pkg::COURSES_W-1:0] courses;
    logic [wksq_pkg::KEY_W-1:0]     key;
  } held_entry_t;

  typedef struct packed {
    queue_cmd_t    stim;
    logic          typed;
    front_report_t want;
  } dir_row_t;

  typedef struct packed {
    logic [wksq_pkg::GRADE_W-1:0]   mg;
    logic [wksq_pkg::COURSES_W-1:0] tc;
    logic [31:0]                    enq_pct;
    logic [31:0]                    n;
    logic                           send_idle;
    logic                           recv_idle;
  } phase_t;

  localparam front_report_t EMPTY_REPORT =
    '{wksq_pkg::STATUS_DONE, '0, '0, '0, '0, '0, 1'b1};
  localparam front_report_t EMPTY_REFUSED =
    '{wksq_pkg::STATUS_EMPTY, '0, '0, '0, '0, '0, 1'b1};
  // 16383*40 + 255*1000 with the reset weights
  localparam logic [wksq_pkg::KEY_W-1:0] TOP_KEY_RST = 23'd910320;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [wksq_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wksq_pkg::CFG_DATA_W-1:0] cfg_data;

  wksq_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_ch ();
  wksq_rsp_if #(.VALUE_WIDTH(VALUE_WIDTH)) rsp_ch ();

  weighted_key_sorted_priority_queue #(
    .CAPACITY(CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow copy of the queue
  held_entry_t                    shadow_slots[CAPACITY];
  int                             shadow_count;
  logic [wksq_pkg::GRADE_W-1:0]   shadow_max;
  logic [wksq_pkg::COURSES_W-1:0] shadow_total;

  front_report_t pending_reports[$];
  dir_row_t      dir_rows[$];
  phase_t        phases[7];
  int            mismatches;
  int            cycles;
  bit            send_idle;
  bit            recv_idle;
  bit            hold_request;
  logic [wksq_pkg::GRADE_W-1:0]   last_grade;
  logic [wksq_pkg::COURSES_W-1:0] last_courses;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("[weighted_key_sorted_priority_queue] ERROR");
      $finish;
    end
  end

  function automatic front_report_t apply_queue_cmd(input queue_cmd_t c);
    front_report_t r;
    held_entry_t   e;
    int            pos;
    logic [31:0]   k;
    r = '0;
    r.status = wksq_pkg::STATUS_DONE;
    if (c.cmd == wksq_pkg::CMD_ENQUEUE) begin
      if (shadow_count >= CAPACITY) begin
        r.status = wksq_pkg::STATUS_FULL;
      end else begin
        k = 32'(c.grade) * 32'(shadow_total) + 32'(c.courses) * 32'(shadow_max);
        e = '{c.value, c.grade, c.courses, k[wksq_pkg::KEY_W-1:0]};
        pos = 0;
        // ahead of every entry with key <= new key
        while (pos < shadow_count && e.key < shadow_slots[pos].key) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
        shadow_slots[pos] = e;
        shadow_count++;
      end
    end else if (c.cmd == wksq_pkg::CMD_DEQUEUE) begin
      if (shadow_count == 0) begin
        r.status = wksq_pkg::STATUS_EMPTY;
      end else begin
        for (int i = 0; i < shadow_count - 1; i++) shadow_slots[i] = shadow_slots[i+1];
        shadow_count--;
      end
    end
    r.entry_count = wksq_pkg::COUNT_W'(shadow_count);
    r.is_empty = (shadow_count == 0);
    if (shadow_count != 0) begin
      r.front_value   = shadow_slots[0].value;
      r.front_grade   = shadow_slots[0].grade;
      r.front_courses = shadow_slots[0].courses;
      r.front_key     = shadow_slots[0].key;
    end
    return r;
  endfunction

  function automatic void add_row(input logic [wksq_pkg::CMD_W-1:0] cmd,
                                  input logic [VALUE_WIDTH-1:0] v,
                                  input logic [wksq_pkg::GRADE_W-1:0] g,
                                  input logic [wksq_pkg::COURSES_W-1:0] c,
                                  input logic typed, input front_report_t want);
    dir_row_t row;
    row.stim  = '{cmd, v, g, c};
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [wksq_pkg::GRADE_W-1:0] pick_grade();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return wksq_pkg::GRADE_W'($urandom);
    endcase
  endfunction

  function automatic logic [wksq_pkg::COURSES_W-1:0] pick_courses();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return wksq_pkg::COURSES_W'($urandom);
    endcase
  endfunction

  function automatic queue_cmd_t rand_cmd(input int enq_pct);
    queue_cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < enq_pct) c.cmd = wksq_pkg::CMD_ENQUEUE;
    else if (r < 90) c.cmd = wksq_pkg::CMD_DEQUEUE;
    else if (r < 96) c.cmd = wksq_pkg::CMD_REPORT;
    else c.cmd = CMD_UNUSED;
    c.value = VALUE_WIDTH'($urandom);
    // repeat the last grade/courses now and then to get key ties
    if ($urandom_range(0, 3) != 0) begin
      last_grade   = pick_grade();
      last_courses = pick_courses();
    end
    c.grade   = last_grade;
    c.courses = last_courses;
    return c;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_cmd(input queue_cmd_t c, input int gap, input logic typed,
                          input front_report_t want);
    front_report_t predicted;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= c.cmd;
    req_ch.item_value <= c.value;
    req_ch.grade      <= c.grade;
    req_ch.courses    <= c.courses;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = apply_queue_cmd(c);
    pending_reports.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_weights(input logic [wksq_pkg::GRADE_W-1:0] mg,
                             input logic [wksq_pkg::COURSES_W-1:0] tc);
    cfg_write <= 1'b1;
    cfg_index <= wksq_pkg::REG_GRADE_CEILING;
    cfg_data  <= mg;
    @(negedge clk);
    cfg_index <= wksq_pkg::REG_COURSE_TOTAL;
    cfg_data  <= wksq_pkg::CFG_DATA_W'(tc);
    @(negedge clk);
    cfg_write    <= 1'b0;
    shadow_max   = mg;
    shadow_total = tc;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    front_report_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("response transfer with nothing pending");
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", want.status, rsp_ch.status);
        check_field("front_value", want.front_value, rsp_ch.front_value);
        check_field("front_grade", want.front_grade, rsp_ch.front_grade);
        check_field("front_courses", want.front_courses, rsp_ch.front_courses);
        check_field("front_key", want.front_key, rsp_ch.front_key);
        check_field("entry_count", want.entry_count, rsp_ch.entry_count);
        check_field("is_empty", want.is_empty, rsp_ch.is_empty);
      end
    end
  end

  // response side: random stalls per transfer while recv_idle is set, plus one long hold on request
  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      gap = recv_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    queue_cmd_t c;
    mismatches   = 0;
    cycles       = 0;
    hold_request = 1'b0;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    last_grade   = '0;
    last_courses = '0;
    shadow_count = 0;
    shadow_max   = wksq_pkg::GRADE_CEILING_RST;
    shadow_total = wksq_pkg::COURSE_TOTAL_RST;
    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = wksq_pkg::REG_GRADE_CEILING;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = wksq_pkg::CMD_REPORT;
    req_ch.item_value = '0;
    req_ch.grade      = '0;
    req_ch.courses    = '0;

    // directed rows
    add_row(wksq_pkg::CMD_REPORT, '0, '0, '0, 1'b1, EMPTY_REPORT);
    add_row(wksq_pkg::CMD_DEQUEUE, '0, '0, '0, 1'b1, EMPTY_REFUSED);
    add_row(CMD_UNUSED, '1, '1, '1, 1'b1, EMPTY_REPORT);
    add_row(wksq_pkg::CMD_ENQUEUE, '1, '1, '1, 1'b1,
            '{wksq_pkg::STATUS_DONE, '1, '1, '1, TOP_KEY_RST, 5'd1, 1'b0});
    add_row(wksq_pkg::CMD_ENQUEUE, '0, '0, '0, 1'b1,
            '{wksq_pkg::STATUS_DONE, '1, '1, '1, TOP_KEY_RST, 5'd2, 1'b0});
    // same key as the front: newest goes first
    add_row(wksq_pkg::CMD_ENQUEUE, 16'h1234, '1, '1, 1'b1,
            '{wksq_pkg::STATUS_DONE, 16'h1234, '1, '1, TOP_KEY_RST, 5'd3, 1'b0});
    add_row(wksq_pkg::CMD_ENQUEUE, 16'hAAAA, 14'h2AAA, 8'h55, 1'b0, EMPTY_REPORT);
    add_row(wksq_pkg::CMD_ENQUEUE, 16'h5555, 14'h1555, 8'hAA, 1'b0, EMPTY_REPORT);
    add_row(wksq_pkg::CMD_ENQUEUE, 16'h0F0F, '0, '0, 1'b0, EMPTY_REPORT);
    add_row(wksq_pkg::CMD_DEQUEUE, '0, '0, '0, 1'b0, EMPTY_REPORT);
    add_row(wksq_pkg::CMD_REPORT, '0, '0, '0, 1'b0, EMPTY_REPORT);
    for (int i = 0; i < CAPACITY - 5; i++)
      add_row(wksq_pkg::CMD_ENQUEUE, VALUE_WIDTH'(16'h0100 + i),
              wksq_pkg::GRADE_W'(i * 1400), wksq_pkg::COURSES_W'(i * 23),
              1'b0, EMPTY_REPORT);
    add_row(wksq_pkg::CMD_ENQUEUE, 16'hBEEF, 14'd500, 8'd9, 1'b0, EMPTY_REPORT);
    add_row(wksq_pkg::CMD_DEQUEUE, '0, '0, '0, 1'b0, EMPTY_REPORT);

    phases[0] = '{14'd16383, 8'd255, 70, 80, 1'b1, 1'b1};
    phases[1] = '{14'd1,     8'd1,   55, 80, 1'b0, 1'b0};
    phases[2] = '{14'd1,     8'd255, 60, 70, 1'b1, 1'b0};
    phases[3] = '{14'd16383, 8'd1,   45, 70, 1'b0, 1'b1};
    phases[4] = '{14'd0,     8'd0,   60, 40, 1'b1, 1'b1};
    phases[5] = '{wksq_pkg::GRADE_W'($urandom_range(1, 16383)),
                  wksq_pkg::COURSES_W'($urandom_range(1, 255)),
                  50, 80, 1'b1, 1'b1};
    phases[6] = '{wksq_pkg::GRADE_CEILING_RST, wksq_pkg::COURSE_TOTAL_RST,
                  30, 80, 1'b1, 1'b1};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].stim, $urandom_range(0, 7), dir_rows[i].typed, dir_rows[i].want);
    req_ch.valid <= 1'b0;
    wait_idle();

    // held entries carry over between phases, so stored keys mix weightings
    foreach (phases[p]) begin
      set_weights(phases[p].mg, phases[p].tc);
      send_idle = phases[p].send_idle;
      recv_idle = phases[p].recv_idle;
      for (int n = 0; n < int'(phases[p].n); n++) begin
        if (p == 1 && n == 10) hold_request = 1'b1;
        if (p == 3 && n == 35) begin
          req_ch.valid <= 1'b0;
          wait_idle();
        end
        c = rand_cmd(int'(phases[p].enq_pct));
        send_cmd(c, send_idle ? $urandom_range(0, 7) : 0, 1'b0, EMPTY_REPORT);
      end
      req_ch.valid <= 1'b0;
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("[weighted_key_sorted_priority_queue] OK");
    end else begin
      $display("[weighted_key_sorted_priority_queue] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/wksq_pkg.sv
design/wksq_if.sv
design/wksq_cell.sv
design/weighted_key_sorted_priority_queue.sv
dv/weighted_key_sorted_priority_queue_test.sv
